// ===== hw/rtl/ltsrr_pkg.sv =====
// ltsrr_pkg: constants and types for the three-sector lidar range reducer
// used by lidar_three_sector_range_reduce; no dependencies
package ltsrr_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int RANGE_BITS_DEF  = 16;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int OUT_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIEW   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET = 2'd3;

    localparam logic [1:0] MODE_MIN  = 2'd0;
    localparam logic [1:0] MODE_MAX  = 2'd1;
    localparam logic [1:0] MODE_MEAN = 2'd2;

    localparam logic [12:0] SCAN_LENGTH_RESET = 13'd1024;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_FIX   = 9'b000000100,
        S_BASE  = 9'b000001000,
        S_SECT  = 9'b000010000,
        S_WAIT  = 9'b000100000,
        S_DLOAD = 9'b001000000,
        S_DITER = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

endpackage

// ===== hw/rtl/lidar_three_sector_range_reduce.sv =====
// lidar_three_sector_range_reduce: per-sector min, max or mean of a lidar scan
// one sequencer around a shared bound-compare unit and a restoring divider
// depends on ltsrr_pkg
// a sample transaction steps through accept, divide-by-three multiply and fix-up,
// sector base, then each sector in turn through the shared compare unit
// at scan end it waits for a free output register, then divides each non-empty sector in mean
// mode (restoring divider, one quotient bit a cycle); the result waits in an output register
// asynchronous active-low reset: counters cleared, config regs to defaults, no result pending
module lidar_three_sector_range_reduce #(
    parameter int MAX_SAMPLES = ltsrr_pkg::MAX_SAMPLES_DEF,
    parameter int RANGE_BITS  = ltsrr_pkg::RANGE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ltsrr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ltsrr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [15:0]                        range_mm,
    input  logic                               sample_valid,
    input  logic                               scan_end,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ltsrr_pkg::OUT_W-1:0]        right_value,
    output logic [ltsrr_pkg::OUT_W-1:0]        front_value,
    output logic [ltsrr_pkg::OUT_W-1:0]        left_value,
    output logic                               right_empty,
    output logic                               front_empty,
    output logic                               left_empty
);

    localparam int RB     = RANGE_BITS;
    localparam int POS_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CNT_W  = POS_W;
    localparam int SW     = RB + CNT_W;
    localparam int NW     = (POS_W > 13) ? POS_W : 13;
    localparam int GW     = NW + 3;
    localparam int PW     = 2 * NW + 1;
    localparam int IT_W   = $clog2(RB);
    localparam longint unsigned RECIP3_L = (64'd1 << (NW + 2)) / 64'd3;
    localparam logic [NW:0] RECIP3 = RECIP3_L[NW:0];
    localparam logic [NW-1:0] MAX_N = NW'(MAX_SAMPLES);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_SAMPLES);
    localparam logic [ltsrr_pkg::OUT_W-1:0] OUT_ONES = ltsrr_pkg::OUT_W'({RB{1'b1}});

    // configuration registers
    logic [1:0]         mode_reg;
    logic [12:0]        length_reg;
    logic [11:0]        view_reg;
    logic signed [11:0] offset_reg;

    ltsrr_pkg::state_t state_reg, state_next;

    logic [RB-1:0]    rng_reg;
    logic             smp_valid_reg;
    logic             last_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [PW-1:0]    prod_reg;
    logic [NW-1:0]    v_reg;
    logic [NW-1:0]    p_reg, p_next;
    logic signed [GW-1:0] base_reg, base_next;
    logic [1:0]       sect_reg, sect_next;

    logic [RB-1:0]    best_reg [3];
    logic [SW-1:0]    sum_reg [3];
    logic [CNT_W-1:0] cnt_reg [3];
    logic [CNT_W-1:0] cnt_next [3];

    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [RB-1:0]    dq_reg, dq_next;
    logic [IT_W-1:0]  it_reg, it_next;

    logic                        out_valid_reg, out_valid_next;
    logic [ltsrr_pkg::OUT_W-1:0] val_reg [3];
    logic                        empty_reg [3];

    // geometry from the registers
    logic [NW-1:0]        len_ext;
    logic [NW-1:0]        n_eff;
    logic [NW-1:0]        v_w;
    logic [NW+1:0]        three_q0;
    logic signed [GW-1:0] n_s;
    logic signed [GW-1:0] p_s;
    logic signed [GW-1:0] end_raw;
    logic signed [GW-1:0] lo_b;
    logic signed [GW-1:0] hi_b;
    logic signed [GW-1:0] pos_s;
    logic                 hit;

    // divider datapath
    logic [SW:0]    numer;
    logic [CNT_W:0] trial;
    logic           ge;

    function automatic logic signed [GW-1:0] clamp_idx(
        input logic signed [GW-1:0] x,
        input logic signed [GW-1:0] n
    );
        logic signed [GW-1:0] r;
        if (x < 0)
        begin
            r = '0;
        end
        else if (x > n - 1)
        begin
            r = n - 1;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

    always_comb
    begin
        len_ext = NW'(length_reg);
        if (len_ext == '0)
        begin
            n_eff = NW'(1);
        end
        else if (len_ext > MAX_N)
        begin
            n_eff = MAX_N;
        end
        else
        begin
            n_eff = len_ext;
        end
        v_w      = (view_reg == '0) ? (n_eff - NW'(1)) : NW'(view_reg);
        three_q0 = (NW+2)'(prod_reg >> (NW + 2)) * (NW+2)'(3);
        n_s      = $signed(GW'(n_eff));
        p_s      = $signed(GW'(p_reg));
        pos_s    = $signed(GW'(pos_reg));
        end_raw  = base_reg + p_s - GW'(1);
        lo_b     = clamp_idx(base_reg, n_s);
        hi_b     = clamp_idx(end_raw, n_s);
        hit      = smp_valid_reg && (pos_s < n_s) && (pos_s >= lo_b) && (pos_s <= hi_b);

        numer = (SW+1)'(sum_reg[sect_reg]) + (SW+1)'(cnt_reg[sect_reg] >> 1);
        trial = {rem_reg, dq_reg[RB-1]};
        ge    = (trial >= {1'b0, cnt_reg[sect_reg]});
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        p_next         = p_reg;
        base_next      = base_reg;
        sect_next      = sect_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        it_next        = it_reg;
        out_valid_next = out_valid_reg && !out_ready;
        for (int k = 0; k < 3; k++)
        begin
            cnt_next[k] = cnt_reg[k];
        end
        case (state_reg)
            ltsrr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ltsrr_pkg::S_MUL;
                end
            end
            ltsrr_pkg::S_MUL:
            begin
                state_next = ltsrr_pkg::S_FIX;
            end
            ltsrr_pkg::S_FIX:
            begin
                p_next = NW'(prod_reg >> (NW + 2));
                if ((NW+2)'(v_reg) - three_q0 >= (NW+2)'(3))
                begin
                    p_next = NW'(prod_reg >> (NW + 2)) + NW'(1);
                end
                state_next = ltsrr_pkg::S_BASE;
            end
            ltsrr_pkg::S_BASE:
            begin
                base_next  = $signed(GW'(n_eff >> 1)) + GW'(offset_reg)
                           - ((p_s + (p_s <<< 1)) >>> 1);
                sect_next  = 2'd0;
                state_next = ltsrr_pkg::S_SECT;
            end
            ltsrr_pkg::S_SECT:
            begin
                if (hit)
                begin
                    cnt_next[sect_reg] = cnt_reg[sect_reg] + CNT_W'(1);
                end
                base_next = base_reg + p_s;
                if (sect_reg == 2'd2)
                begin
                    if (pos_reg < MAX_POS)
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    state_next = last_reg ? ltsrr_pkg::S_WAIT : ltsrr_pkg::S_IDLE;
                end
                else
                begin
                    sect_next = sect_reg + 2'd1;
                end
            end
            ltsrr_pkg::S_WAIT:
            begin
                sect_next = 2'd0;
                if (!out_valid_reg)
                begin
                    state_next = ltsrr_pkg::S_DLOAD;
                end
            end
            ltsrr_pkg::S_DLOAD:
            begin
                if (mode_reg == ltsrr_pkg::MODE_MEAN && cnt_reg[sect_reg] != '0)
                begin
                    rem_next   = CNT_W'(numer[SW:RB]);
                    dq_next    = numer[RB-1:0];
                    it_next    = IT_W'(RB - 1);
                    state_next = ltsrr_pkg::S_DITER;
                end
                else if (sect_reg == 2'd2)
                begin
                    state_next = ltsrr_pkg::S_DONE;
                end
                else
                begin
                    sect_next = sect_reg + 2'd1;
                end
            end
            ltsrr_pkg::S_DITER:
            begin
                rem_next = ge ? CNT_W'(trial - {1'b0, cnt_reg[sect_reg]}) : CNT_W'(trial);
                dq_next  = {dq_reg[RB-2:0], ge};
                it_next  = it_reg - IT_W'(1);
                if (it_reg == '0)
                begin
                    if (sect_reg == 2'd2)
                    begin
                        state_next = ltsrr_pkg::S_DONE;
                    end
                    else
                    begin
                        sect_next  = sect_reg + 2'd1;
                        state_next = ltsrr_pkg::S_DLOAD;
                    end
                end
            end
            ltsrr_pkg::S_DONE:
            begin
                out_valid_next = 1'b1;
                pos_next       = '0;
                for (int k = 0; k < 3; k++)
                begin
                    cnt_next[k] = '0;
                end
                state_next = ltsrr_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ltsrr_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ltsrr_pkg::S_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                cnt_reg[k] <= '0;
            end
            mode_reg   <= ltsrr_pkg::MODE_MIN;
            length_reg <= ltsrr_pkg::SCAN_LENGTH_RESET;
            view_reg   <= '0;
            offset_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < 3; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    ltsrr_pkg::CFG_MODE:   mode_reg   <= cfg_data[1:0];
                    ltsrr_pkg::CFG_LENGTH: length_reg <= cfg_data[12:0];
                    ltsrr_pkg::CFG_VIEW:   view_reg   <= cfg_data[11:0];
                    ltsrr_pkg::CFG_OFFSET: offset_reg <= $signed(cfg_data[11:0]);
                    default:               mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    // datapath, first sample of a sector overwrites best and sum
    always_ff @(posedge clk)
    begin
        if (state_reg == ltsrr_pkg::S_IDLE && in_valid)
        begin
            rng_reg       <= RB'(range_mm);
            smp_valid_reg <= sample_valid;
            last_reg      <= scan_end;
        end
        if (state_reg == ltsrr_pkg::S_MUL)
        begin
            prod_reg <= PW'(v_w) * PW'(RECIP3);
            v_reg    <= v_w;
        end
        p_reg    <= p_next;
        base_reg <= base_next;
        sect_reg <= sect_next;
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        it_reg   <= it_next;
        if (state_reg == ltsrr_pkg::S_SECT && hit)
        begin
            if (cnt_reg[sect_reg] == '0)
            begin
                best_reg[sect_reg] <= rng_reg;
                sum_reg[sect_reg]  <= SW'(rng_reg);
            end
            else
            begin
                sum_reg[sect_reg] <= sum_reg[sect_reg] + SW'(rng_reg);
                if (mode_reg == ltsrr_pkg::MODE_MAX)
                begin
                    if (rng_reg > best_reg[sect_reg])
                    begin
                        best_reg[sect_reg] <= rng_reg;
                    end
                end
                else if (rng_reg < best_reg[sect_reg])
                begin
                    best_reg[sect_reg] <= rng_reg;
                end
            end
        end
        if (state_reg == ltsrr_pkg::S_DLOAD
            && !(mode_reg == ltsrr_pkg::MODE_MEAN && cnt_reg[sect_reg] != '0))
        begin
            empty_reg[sect_reg] <= (cnt_reg[sect_reg] == '0);
            if (cnt_reg[sect_reg] == '0)
            begin
                val_reg[sect_reg] <= (mode_reg == ltsrr_pkg::MODE_MAX) ? '0 : OUT_ONES;
            end
            else
            begin
                val_reg[sect_reg] <= ltsrr_pkg::OUT_W'(best_reg[sect_reg]);
            end
        end
        if (state_reg == ltsrr_pkg::S_DITER && it_reg == '0)
        begin
            empty_reg[sect_reg] <= 1'b0;
            val_reg[sect_reg]   <= ltsrr_pkg::OUT_W'(dq_next);
        end
    end

    assign in_ready    = (state_reg == ltsrr_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign right_value = val_reg[0];
    assign front_value = val_reg[1];
    assign left_value  = val_reg[2];
    assign right_empty = empty_reg[0];
    assign front_empty = empty_reg[1];
    assign left_empty  = empty_reg[2];

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a transaction is in progress");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ltsrr_pkg::S_IDLE |-> POS_W'(cnt_reg[1]) <= pos_reg)
        else $error("sector count exceeds sample position");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ltsrr_pkg::S_DITER |-> rem_reg < cnt_reg[sect_reg])
        else $error("divider remainder not below divisor");

endmodule
